>>> src/mvdi_pkg.sv
// ----------------------------------------------------------------------------
// mvdi_pkg
// Shared types and constants of the vertex deduplication indexer.
// ----------------------------------------------------------------------------
package mvdi_pkg;

   localparam int MAX_VERTICES_DEF = 4096;
   localparam int COORD_WIDTH_DEF  = 64;
   localparam int FIELD_W          = 64;
   localparam int VIDX_W           = 12;

   typedef struct packed {
      logic [FIELD_W-1:0] coord_x;
      logic [FIELD_W-1:0] coord_y;
      logic [FIELD_W-1:0] coord_z;
      logic               start_mesh;
   } req_type;

   typedef struct packed {
      logic [VIDX_W-1:0] vertex_index;
      logic              is_new;
      logic              table_full;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic rd;
      logic adv;
      logic append;
      logic hit;
      logic full;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_end;
      logic match;
      logic full;
   } sts_type;

endpackage

>>> src/mvdi_datapath.sv
// ----------------------------------------------------------------------------
// mvdi_datapath
// Vertex store, scan pointer, vertex count and result word register.
// ----------------------------------------------------------------------------
module mvdi_datapath #(
   parameter int MAX_VERTICES = mvdi_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = mvdi_pkg::COORD_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  mvdi_pkg::req_type req_data,
   input  mvdi_pkg::cmd_type cmd,
   output mvdi_pkg::sts_type sts,
   output mvdi_pkg::rsp_type rsp_data
);
   import mvdi_pkg::*;

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int KEY_W = 3 * COORD_WIDTH;

   logic [KEY_W-1:0] mem [MAX_VERTICES];
   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] rd_data_ff;
   logic [IDX_W:0]   scan_ff;
   logic [IDX_W:0]   count_ff;
   rsp_type          rsp_ff;

   // storage and payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff  <= {req_data.coord_x[COORD_WIDTH-1:0], req_data.coord_y[COORD_WIDTH-1:0],
                     req_data.coord_z[COORD_WIDTH-1:0]};
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[scan_ff[IDX_W-1:0]];
      end
      if (cmd.append) begin
         mem[count_ff[IDX_W-1:0]] <= key_ff;
         rsp_ff <= '{vertex_index: VIDX_W'(count_ff), is_new: 1'b1, table_full: 1'b0};
      end else if (cmd.hit) begin
         rsp_ff <= '{vertex_index: VIDX_W'(scan_ff), is_new: 1'b0, table_full: 1'b0};
      end else if (cmd.full) begin
         rsp_ff <= '{vertex_index: '0, is_new: 1'b0, table_full: 1'b1};
      end
   end

   // count and scan pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         scan_ff  <= '0;
      end else begin
         if (cmd.load) begin
            scan_ff <= '0;
            if (req_data.start_mesh) begin
               count_ff <= '0;
            end
         end else if (cmd.adv) begin
            scan_ff <= scan_ff + 1'b1;
         end
         if (cmd.append) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   assign sts.scan_end = (scan_ff == count_ff);
   assign sts.match    = (rd_data_ff == key_ff);
   assign sts.full     = (count_ff == (IDX_W+1)'(MAX_VERTICES));
   assign rsp_data     = rsp_ff;

endmodule

>>> src/mvdi_ctrl.sv
// ----------------------------------------------------------------------------
// mvdi_ctrl
// Sequencer: accept a vertex, scan the store, append or answer, hand out.
// ----------------------------------------------------------------------------
module mvdi_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  mvdi_pkg::sts_type sts,
   output mvdi_pkg::cmd_type cmd
);
   import mvdi_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP, S_OUT} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (sts.scan_end) begin
               if (sts.full) begin
                  cmd.full = 1'b1;
               end else begin
                  cmd.append = 1'b1;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_OUT;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.match) begin
               cmd.hit      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_OUT;
            end else begin
               cmd.adv  = 1'b1;
               state_in = S_READ;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the input closed during reset so no word is taken and dropped
   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/mesh_vertex_dedup_indexer_unit.sv
// ----------------------------------------------------------------------------
// mesh_vertex_dedup_indexer_unit
// Vertex deduplication indexer: maps corner vertices to distinct table indices.
// ----------------------------------------------------------------------------
// Each accepted word carries one corner vertex. The unit scans the stored
// distinct vertices in insertion order, each entry by a read of the vertex
// store and then a compare of all three coordinates, and answers with the
// index of the first match. With no match the vertex is appended at the next
// free index and flagged new; with no room the result word has table_full
// set and index zero. A set start_mesh empties the table first, so that
// vertex lands at index zero. One vertex is in flight at a time: the result
// word is offered once the scan ends at a match or at the last entry, and is
// held until the consumer takes it. The input reopens on the cycle after that
// handshake. Only the low COORD_WIDTH bits of each coordinate take part in
// the compare; the index carries its low 12 bits. The input is held closed
// while reset is high.
// ----------------------------------------------------------------------------
module mesh_vertex_dedup_indexer_unit #(
   parameter int MAX_VERTICES = mvdi_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = mvdi_pkg::COORD_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mvdi_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mvdi_pkg::rsp_type rsp_data
);
   import mvdi_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequence the scan
   mvdi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold the store, the count and the result word
   mvdi_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   // a pending result blocks new vertices
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("result pending while input open");

   // an accepted vertex closes the input at once
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open after accept");

   // new and full never together
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_new && rsp_data.table_full))
      else $error("is_new and table_full both set");

endmodule
